[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL of the digest core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

[src/sha256md_pkg.sv]
// ----------------------------------------------------------------------------
// sha256md_pkg
// Types, constants and helper functions of the SHA-256 digest core.
// ----------------------------------------------------------------------------
package sha256md_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // Padding phases after the last message word
    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LENLO,
        PH_DONE
    } phase_t;

    // Eight 32-bit words, index 0 is a / H0
    typedef logic [7:0][31:0] words8_t;

    // Control from the sequencer to the schedule window
    typedef struct packed {
        logic        step;
        logic        load;
        logic [31:0] word;
    } sched_ctrl_t;

    localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Rotate a word right by a fixed amount
    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[src/sha256md_sched.sv]
// ----------------------------------------------------------------------------
// sha256md_sched
// Sixteen-word message schedule window, shifted once per push or round.
// ----------------------------------------------------------------------------
module sha256md_sched (
    input  logic                     clk,
    input  sha256md_pkg::sched_ctrl_t ctrl,
    output logic [31:0]              w_cur
);

    logic [15:0][31:0] win_reg;
    logic [31:0]       s0;
    logic [31:0]       s1;
    logic [31:0]       w_new;

    // Expand the next schedule word from the window taps
    always_comb
    begin
        s0 = sha256md_pkg::rotr(win_reg[1], 7) ^ sha256md_pkg::rotr(win_reg[1], 18)
           ^ (win_reg[1] >> 3);
        s1 = sha256md_pkg::rotr(win_reg[14], 17) ^ sha256md_pkg::rotr(win_reg[14], 19)
           ^ (win_reg[14] >> 10);
        w_new = s1 + win_reg[9] + s0 + win_reg[0];
    end

    // Shift down and append a loaded or expanded word
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= ctrl.load ? ctrl.word : w_new;
        end
    end

    assign w_cur = win_reg[0];

endmodule

[src/sha256md_round.sv]
// ----------------------------------------------------------------------------
// sha256md_round
// One SHA-256 compression round on the working variables a..h.
// ----------------------------------------------------------------------------
module sha256md_round (
    input  sha256md_pkg::words8_t vars_in,
    input  logic [31:0]           w,
    input  logic [31:0]           k,
    output sha256md_pkg::words8_t vars_out
);

    logic [31:0] sig0;
    logic [31:0] sig1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    // Compute both temporaries and rotate the variables
    always_comb
    begin
        sig1 = sha256md_pkg::rotr(vars_in[4], 6) ^ sha256md_pkg::rotr(vars_in[4], 11)
             ^ sha256md_pkg::rotr(vars_in[4], 25);
        ch   = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
        sig0 = sha256md_pkg::rotr(vars_in[0], 2) ^ sha256md_pkg::rotr(vars_in[0], 13)
             ^ sha256md_pkg::rotr(vars_in[0], 22);
        maj  = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
             ^ (vars_in[1] & vars_in[2]);
        t1   = vars_in[7] + sig1 + ch + k + w;
        t2   = sig0 + maj;
        vars_out[7] = vars_in[6];
        vars_out[6] = vars_in[5];
        vars_out[5] = vars_in[4];
        vars_out[4] = vars_in[3] + t1;
        vars_out[3] = vars_in[2];
        vars_out[2] = vars_in[1];
        vars_out[1] = vars_in[0];
        vars_out[0] = t1 + t2;
    end

endmodule

[src/sha256_message_digest_core.sv]
// ----------------------------------------------------------------------------
// sha256_message_digest_core
// SHA-256 digest of a word stream with padding and length appended in hardware.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries message words: tdata holds the 32-bit word with the
//   first byte in bits 31..24 and the valid byte count in bits 34..32; tlast
//   marks the final word, whose byte count (0..4) is honored.
//   Master stream returns eight digest words, H0 first, with their index in
//   tdata bits 34..32 and tlast on the eighth word.
// Flow:
//   Words that do not complete a 64-byte block are accepted back to back.
//   The sixteenth word of a block starts 64 rounds on the single round unit,
//   followed by the hash update. After the last word, padding words are
//   pushed one after another, each padded block again runs the rounds and
//   the hash update, then eight digest transfers follow.
//   s_tready is low while rounds, padding or digest output are under way.
// Reset and stall:
//   Reset loads the initial hash values and clears counters. A stalled
//   receiver holds the current digest word; the core resumes on the next
//   transfer and returns to the initial hash after the eighth.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_message_digest_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], valid_bytes[34:32], zero fill
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast    // digest_last
);

    sha256md_pkg::state_t      state_reg, state_next;
    sha256md_pkg::phase_t      phase_reg, phase_next;
    sha256md_pkg::words8_t     hash_reg, hash_next;
    sha256md_pkg::words8_t     vars_reg, vars_next;
    sha256md_pkg::words8_t     vars_round;
    sha256md_pkg::sched_ctrl_t sched_ctrl;
    logic [5:0]                round_reg, round_next;
    logic [3:0]                wib_reg, wib_next;
    logic [63:0]               bitlen_reg, bitlen_next;
    logic [2:0]                idx_reg, idx_next;
    logic [31:0]               w_cur;
    logic [31:0]               data_word;
    logic [2:0]                valid_bytes;
    logic [2:0]                nb_sat;
    logic [31:0]               tail_word;
    logic                      push_en;
    logic [31:0]               push_word;

    assign data_word   = s_tdata[31:0];
    assign valid_bytes = s_tdata[34:32];

    sha256md_sched u_sched (
        .clk   (clk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    sha256md_round u_round (
        .vars_in  (vars_reg),
        .w        (w_cur),
        .k        (sha256md_pkg::ROUND_K[round_reg]),
        .vars_out (vars_round)
    );

    // Clamp the byte count and merge the marker into a short last word
    always_comb
    begin
        nb_sat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nb_sat)
            3'd0:    tail_word = sha256md_pkg::PAD_MARKER;
            3'd1:    tail_word = {data_word[31:24], 24'h80_0000};
            3'd2:    tail_word = {data_word[31:16], 16'h8000};
            3'd3:    tail_word = {data_word[31:8], 8'h80};
            default: tail_word = data_word;
        endcase
    end

    // Sequence pushes, rounds, hash update and digest output
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        hash_next   = hash_reg;
        vars_next   = vars_reg;
        round_next  = round_reg;
        wib_next    = wib_reg;
        bitlen_next = bitlen_reg;
        idx_next    = idx_reg;
        push_en     = 1'b0;
        push_word   = '0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        case (state_reg)
            sha256md_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    push_en = 1'b1;
                    if (!s_tlast)
                    begin
                        push_word   = data_word;
                        bitlen_next = bitlen_reg + 64'd32;
                    end
                    else
                    begin
                        push_word   = tail_word;
                        bitlen_next = bitlen_reg + {58'd0, nb_sat, 3'd0};
                        phase_next  = (nb_sat == 3'd4) ? sha256md_pkg::PH_MARK
                                                       : sha256md_pkg::PH_ZERO;
                    end
                    if (wib_reg == 4'd15)
                    begin
                        state_next = sha256md_pkg::ST_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        state_next = sha256md_pkg::ST_PAD;
                    end
                end
            end
            sha256md_pkg::ST_PAD:
            begin
                push_en = 1'b1;
                case (phase_reg)
                    sha256md_pkg::PH_MARK:
                    begin
                        push_word  = sha256md_pkg::PAD_MARKER;
                        phase_next = sha256md_pkg::PH_ZERO;
                    end
                    sha256md_pkg::PH_ZERO:
                    begin
                        if (wib_reg == 4'd14)
                        begin
                            push_word  = bitlen_reg[63:32];
                            phase_next = sha256md_pkg::PH_LENLO;
                        end
                    end
                    sha256md_pkg::PH_LENLO:
                    begin
                        push_word  = bitlen_reg[31:0];
                        phase_next = sha256md_pkg::PH_DONE;
                    end
                    default:
                    begin
                        push_word = '0;
                    end
                endcase
                if (wib_reg == 4'd15)
                begin
                    state_next = sha256md_pkg::ST_ROUND;
                end
            end
            sha256md_pkg::ST_ROUND:
            begin
                vars_next  = vars_round;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = sha256md_pkg::ST_FINAL;
                end
            end
            sha256md_pkg::ST_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                if (phase_reg == sha256md_pkg::PH_DONE)
                begin
                    state_next = sha256md_pkg::ST_OUT;
                end
                else if (phase_reg != sha256md_pkg::PH_NONE)
                begin
                    state_next = sha256md_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256md_pkg::ST_IDLE;
                end
            end
            sha256md_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[i] = sha256md_pkg::INIT_HASH[i];
                        end
                        bitlen_next = '0;
                        phase_next  = sha256md_pkg::PH_NONE;
                        state_next  = sha256md_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256md_pkg::ST_IDLE;
            end
        endcase

        // Count pushed words and load the working variables on a full block
        if (push_en)
        begin
            wib_next = wib_reg + 4'd1;
            if (wib_reg == 4'd15)
            begin
                vars_next  = hash_reg;
                round_next = '0;
            end
        end
    end

    // Drive the schedule window
    always_comb
    begin
        sched_ctrl.step = push_en || (state_reg == sha256md_pkg::ST_ROUND);
        sched_ctrl.load = push_en;
        sched_ctrl.word = push_word;
    end

    // Hold sequencer and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256md_pkg::ST_IDLE;
            phase_reg  <= sha256md_pkg::PH_NONE;
            vars_reg   <= '0;
            round_reg  <= '0;
            wib_reg    <= '0;
            bitlen_reg <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha256md_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            hash_reg   <= hash_next;
            vars_reg   <= vars_next;
            round_reg  <= round_next;
            wib_reg    <= wib_next;
            bitlen_reg <= bitlen_next;
            idx_reg    <= idx_next;
        end
    end

    // Present the current digest word
    assign m_tdata = {5'd0, idx_reg, hash_reg[idx_reg]};
    assign m_tlast = (idx_reg == 3'd7);

    `ASSERT_SAME(a_out_blocks_in, clk, rst_n, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_round_end, clk, rst_n,
        (state_reg == sha256md_pkg::ST_ROUND) && (round_reg == 6'd63),
        state_reg == sha256md_pkg::ST_FINAL)
    `ASSERT_NEXT(a_digest_clear, clk, rst_n, m_tvalid && m_tready && m_tlast,
        (wib_reg == 4'd0) && (bitlen_reg == 64'd0) && s_tready)
    `ASSERT_SAME(a_round_block_start, clk, rst_n,
        (state_reg == sha256md_pkg::ST_ROUND) && (round_reg == 6'd0), wib_reg == 4'd0)

endmodule

[tb/sha256_message_digest_core_tb.sv]
// ============================================================================
// sha256_message_digest_core_tb
// Self-checking testbench of the SHA-256 message digest core.
// Message words go in on the slave stream in random bursts. A model of the
// hash in the testbench predicts the eight digest words of every message.
// Each digest transfer on the master stream is compared with the oldest
// prediction. The receiver stalls on its own pattern, and once it holds off
// long enough to back the core up.
// ============================================================================
module sha256_message_digest_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int END_WAIT    = 200;
    localparam int RANDOM_WORDS = 100;
    localparam int MAX_PRINTS  = 50;
    localparam logic [31:0] PAD_BYTE_WORD = 32'h8000_0000;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_word;
    } digest_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // data_word[31:0], valid_bytes[34:32], zero fill
    logic        s_tlast  = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // digest_word[31:0], word_index[34:32], zero fill
    logic        m_tlast;         // digest_last

    // Hash state of the model
    logic [31:0] hash_state [8];
    logic [31:0] msg_window [16];
    int unsigned window_fill;
    logic [63:0] msg_bits;

    digest_beat_t digest_q [$];

    int err_count = 0;
    int cycle_count = 0;

    // Sender and receiver pacing
    bit tx_idle_en  = 1'b0;
    int burst_left  = 0;
    bit rx_stall_en = 1'b0;
    bit rx_ready_phase = 1'b1;
    int rx_run_left = 0;
    bit hold_go = 1'b0;
    int hold_len = 0;
    int hold_left = 0;

    sha256_message_digest_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest model
    // ------------------------------------------------------------------
    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = HASH_IV[i];
        window_fill = 0;
        msg_bits = '0;
    endtask

    task automatic compress_window();
        logic [31:0] v [8];
        logic [31:0] w, t1, t2, x2, x15;
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w = msg_window[t];
            else
            begin
                x2  = msg_window[(t - 2) & 15];
                x15 = msg_window[(t - 15) & 15];
                w = (rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10))
                  + msg_window[(t - 7) & 15]
                  + (rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3))
                  + msg_window[t & 15];
                msg_window[t & 15] = w;
            end
            t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w;
            t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic append_word(input logic [31:0] w);
        msg_window[window_fill] = w;
        window_fill++;
        if (window_fill == 16)
        begin
            compress_window();
            window_fill = 0;
        end
    endtask

    // Absorb one message word; queue the digest on the last one
    task automatic absorb_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
        int unsigned nbytes;
        logic [31:0] keep;
        digest_beat_t beat;
        if (!last)
        begin
            append_word(data);
            msg_bits = msg_bits + 64'd32;
        end
        else
        begin
            nbytes = (nb > 3'd4) ? 4 : nb;
            msg_bits = msg_bits + 64'(nbytes * 8);
            if (nbytes == 4)
            begin
                append_word(data);
                append_word(PAD_BYTE_WORD);
            end
            else
            begin
                keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
                append_word((data & keep) | (32'h80 << (24 - 8 * nbytes)));
            end
            while (window_fill != 14)
                append_word(32'h0);
            append_word(msg_bits[63:32]);
            append_word(msg_bits[31:0]);
            for (int i = 0; i < 8; i++)
            begin
                beat.word = hash_state[i];
                beat.index = 3'(i);
                beat.final_word = (i == 7);
                digest_q.push_back(beat);
            end
            restart_hash();
        end
    endtask

    // Predict on every accepted input transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            absorb_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        if (err_count < MAX_PRINTS)
            $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, exp);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest word", m_tdata[31:0], 32'h0);
            else
            begin
                exp_beat = digest_q.pop_front();
                if (m_tdata[31:0] !== exp_beat.word)
                    report_mismatch("digest_word", m_tdata[31:0], exp_beat.word);
                if (m_tdata[34:32] !== exp_beat.index)
                    report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(exp_beat.index));
                if (m_tlast !== exp_beat.final_word)
                    report_mismatch("digest_last", 32'(m_tlast), 32'(exp_beat.final_word));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_left = hold_len;
            hold_go = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!rx_stall_en)
            m_tready <= 1'b1;
        else
        begin
            if (rx_run_left == 0)
            begin
                rx_ready_phase = !rx_ready_phase;
                rx_run_left = rx_ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 6);
            end
            rx_run_left--;
            m_tready <= rx_ready_phase;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
        int gap;
        if (tx_idle_en && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0)
            burst_left--;
        s_tdata  <= {5'b0, nb, data};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every queued digest word has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (digest_q.size() != 0);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_message();
        // Junk data in an empty last word must be ignored
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_partial_last_word();
        // Three valid bytes, the unused low byte set
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd1, 1'b1);
        wait_drained();
    endtask

    task automatic test_oversize_byte_count();
        // Counts above four saturate
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_word(32'h0123_4567, 3'd5, 1'b1);
        wait_drained();
    endtask

    task automatic test_short_nonlast_words();
        // Byte count is ignored on words that are not last
        send_word(32'h1234_5678, 3'd1, 1'b0);
        send_word(32'hA5A5_A5A5, 3'd2, 1'b0);
        send_word(32'hDEAD_BEEF, 3'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_second_pad_block();
        // 60 bytes leave no room for the length: padding spills into a new block
        for (int i = 0; i < 14; i++)
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // Hold the receiver off while two messages are offered back to back
        hold_len = 400;
        hold_go = 1'b1;
        for (int i = 0; i < 3; i++)
            send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd2, 1'b1);
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        logic [31:0] data;
        sent = 0;
        tx_idle_en = 1'b1;
        rx_stall_en = 1'b1;
        while (sent < RANDOM_WORDS)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 13);
            for (int i = 0; i <= len; i++)
            begin
                case ($urandom_range(0, 7))
                    0: data = 32'h0;
                    1: data = 32'hFFFF_FFFF;
                    default: data = $urandom;
                endcase
                send_word(data, 3'($urandom_range(0, 7)), i == len);
                sent++;
            end
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        restart_hash();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_partial_last_word();
        test_oversize_byte_count();
        test_short_nonlast_words();
        test_second_pad_block();
        test_backpressure();
        test_random_messages();

        // Let any stray output show up
        repeat (END_WAIT) @(posedge clk);
        if (digest_q.size() != 0)
            report_mismatch("digest words never sent", 32'(digest_q.size()), 32'h0);

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // End the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
